>>> src/bmv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_pkg: shared types and constants of the band matrix-vector multiplier
// Item and result payloads, operation and register codes, sequencer states
// and the control group of the shared multiplier.
// ----------------------------------------------------------------------------
package bmv_pkg;

	localparam int DATA_W    = 16;  // element width, signed Q8.8
	localparam int FRAC_W    = 8;   // fraction bits of an element
	localparam int IDX_W     = 6;   // row and column index width
	localparam int MAX_DIM   = 64;  // rows and columns held in the stores
	localparam int DIM_W     = 7;   // width of row_count and col_count
	localparam int BW_W      = 4;   // width of lower_width and upper_width
	localparam int BW_MAX    = 15;  // largest bandwidth the registers can hold
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 16;  // widest configuration register

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_X = 2'd1,
		OP_LOAD_Y = 2'd2,
		OP_START  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_COUNT   = 3'd0,
		REG_COL_COUNT   = 3'd1,
		REG_LOWER_WIDTH = 3'd2,
		REG_UPPER_WIDTH = 3'd3,
		REG_ALPHA_GAIN  = 3'd4,
		REG_BETA_GAIN   = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ROW,
		ST_MAC,
		ST_ALPHA,
		ST_BETA,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_BAND,
		MUL_ALPHA,
		MUL_BETA
	} mul_sel_t;

	typedef struct packed {
		logic     en;
		mul_sel_t sel;
	} mul_ctrl_t;

	typedef struct packed {
		op_t                      op;
		logic [IDX_W-1:0]         row;
		logic [IDX_W-1:0]         col;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] y_value;
		logic [IDX_W-1:0]         y_index;
		logic                     last;
	} result_t;

endpackage

>>> src/bmv_mul_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_mul_unit: shared signed multiplier with operand selection
// One registered multiplier serves the band products, the alpha scaling of
// the row sum and the beta scaling of the old y element.
// ----------------------------------------------------------------------------
module bmv_mul_unit import bmv_pkg::*; #(
	parameter int ACC_W = 37
) (
	input  logic                             clk,
	input  mul_ctrl_t                        ctrl,
	input  logic signed [DATA_W-1:0]         band_rd,
	input  logic signed [DATA_W-1:0]         x_rd,
	input  logic signed [DATA_W-1:0]         y_rd,
	input  logic signed [ACC_W-1:0]          acc,
	input  logic signed [DATA_W-1:0]         alpha,
	input  logic signed [DATA_W-1:0]         beta,
	output logic signed [ACC_W+DATA_W-1:0]   prod_s2
);

	logic signed [ACC_W-1:0]  opa;
	logic signed [DATA_W-1:0] opb;

	always_comb begin
		case (ctrl.sel)
			MUL_BAND: begin
				opa = ACC_W'(band_rd);
				opb = x_rd;
			end
			MUL_ALPHA: begin
				opa = acc;
				opb = alpha;
			end
			MUL_BETA: begin
				opa = ACC_W'(y_rd);
				opb = beta;
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_s2 <= (ACC_W+DATA_W)'(opa) * (ACC_W+DATA_W)'(opb);
		end
	end

endmodule

>>> src/band_matrix_vector_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_matrix_vector_multiply: y = alpha*A*x + beta*y for a band matrix
// Load items fill the band, x and y stores; a start item walks every row
// over its band with one shared multiplier and emits the saturated results.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  item      in         item_valid / item_stall   item_t   (op, row, col, value)
//  result    out        result_valid / result_stall result_t (y_value, y_index, last)
//  cfg       in         cfg_write                 cfg_index, cfg_data
//
// A load item is written into its store as it is accepted. A start item
// walks each row through the states row, mac, alpha, beta, sum and out;
// in mac the n band elements of the row (at most 31 with the default band
// store, none for a row wholly right of the matrix) pass one by one through
// the single shared multiplier and the one read port of the band memory.
// After reset the band memory is swept to zero, one entry a cycle, over
// all MAX_DIM * 2**DIAG_W entries (2048 at the default sizes); item_stall
// stays high during the sweep while configuration writes are taken.
// A result waits in its output register while result_stall is high, and the
// sequencer holds at the end of the next row until that register is free.
//
module band_matrix_vector_multiply import bmv_pkg::*; #(
	parameter int MAX_LOWER = 15,
	parameter int MAX_UPPER = 15
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 item_valid,
	output logic                 item_stall,
	input  item_t                item,

	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,

	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// Band geometry. Each row owns a power-of-two slot of diagonals so that
	// the memory address is just the row index next to the diagonal index.
	localparam int BAND_SPAN  = MAX_LOWER + MAX_UPPER + 1;
	localparam int DIAG_W     = (BAND_SPAN > 1) ? $clog2(BAND_SPAN) : 1;
	localparam int BAND_AW    = IDX_W + DIAG_W;
	localparam int BAND_DEPTH = MAX_DIM << DIAG_W;
	localparam int SD_W       = IDX_W + DIAG_W + 2;

	// The bandwidth registers are four bits wide, so a band wider than
	// fifteen diagonals on a side is never used.
	localparam int LW_CAP  = (MAX_LOWER < BW_MAX) ? MAX_LOWER : BW_MAX;
	localparam int UW_CAP  = (MAX_UPPER < BW_MAX) ? MAX_UPPER : BW_MAX;
	localparam int MAX_N   = LW_CAP + UW_CAP + 1;
	localparam int CNT_W   = $clog2(MAX_N + 1);

	// Exact row sum, then the scaled total before rounding.
	localparam int ACC_W  = 2 * DATA_W + $clog2(MAX_N);
	localparam int PROD_W = ACC_W + DATA_W;
	localparam int SUM_W  = PROD_W + 1;

	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (2 * FRAC_W - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'((2 ** (DATA_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO     = -SAT_HI - SUM_W'(1);

	// Configuration registers.
	logic [DIM_W-1:0]         row_count_q;
	logic [DIM_W-1:0]         col_count_q;
	logic [BW_W-1:0]          lower_width_q;
	logic [BW_W-1:0]          upper_width_q;
	logic signed [DATA_W-1:0] alpha_gain_q;
	logic signed [DATA_W-1:0] beta_gain_q;

	// Sequencer.
	state_t                   state_q;
	state_t                   state_nxt;
	logic [BAND_AW-1:0]       clr_addr_q;
	logic [IDX_W-1:0]         i_q;
	logic [IDX_W-1:0]         j_q;
	logic [DIAG_W-1:0]        diag_q;
	logic [CNT_W-1:0]         cnt_q;
	logic                     rd_vld_s1;
	logic                     prod_vld_s2;

	// Datapath registers.
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [PROD_W-1:0] tot_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     out_valid_q;
	result_t                  out_q;

	// Stores and their registered read data.
	logic signed [DATA_W-1:0] band_mem [BAND_DEPTH];
	logic signed [DATA_W-1:0] x_mem    [MAX_DIM];
	logic signed [DATA_W-1:0] y_mem    [MAX_DIM];
	logic signed [DATA_W-1:0] band_rd_q;
	logic signed [DATA_W-1:0] x_rd_q;
	logic signed [DATA_W-1:0] y_rd_q;

	// Combinational signals.
	logic                     accept;
	logic [BW_W-1:0]          lw_eff;
	logic [BW_W-1:0]          uw_eff;
	logic [DIM_W-1:0]         rows_eff;
	logic [DIM_W-1:0]         cols_eff;
	logic signed [SD_W-1:0]   load_d;
	logic signed [SD_W-1:0]   load_diag;
	logic                     load_in_band;
	logic [IDX_W-1:0]         lo_skip;
	logic [IDX_W-1:0]         row_lo;
	logic [DIM_W-1:0]         row_hi;
	logic [DIM_W-1:0]         hi_raw;
	logic [DIM_W-1:0]         row_len;
	logic                     last_row;
	logic                     out_free;
	logic                     issue;
	logic                     out_load;
	mul_ctrl_t                mul_ctrl;
	logic                     band_we;
	logic [BAND_AW-1:0]       band_wr_addr;
	logic signed [DATA_W-1:0] band_wr_data;
	logic                     x_we;
	logic                     y_we;
	logic [IDX_W-1:0]         y_wr_addr;
	logic signed [DATA_W-1:0] y_wr_data;
	logic signed [SUM_W-1:0]  scaled;
	logic signed [DATA_W-1:0] y_sat;

	assign accept = item_valid && !item_stall;

	// Sizes and bandwidths as the walk uses them: a size of zero acts as
	// one, sizes beyond the store act as the store, bandwidths saturate.
	always_comb begin
		lw_eff = (lower_width_q > BW_W'(LW_CAP)) ? BW_W'(LW_CAP) : lower_width_q;
		uw_eff = (upper_width_q > BW_W'(UW_CAP)) ? BW_W'(UW_CAP) : upper_width_q;

		if (row_count_q == '0) begin
			rows_eff = DIM_W'(1);
		end else if (row_count_q > DIM_W'(MAX_DIM)) begin
			rows_eff = DIM_W'(MAX_DIM);
		end else begin
			rows_eff = row_count_q;
		end

		if (col_count_q == '0) begin
			cols_eff = DIM_W'(1);
		end else if (col_count_q > DIM_W'(MAX_DIM)) begin
			cols_eff = DIM_W'(MAX_DIM);
		end else begin
			cols_eff = col_count_q;
		end
	end

	// An element of A is kept only when its diagonal lies inside the band.
	always_comb begin
		load_d       = SD_W'(signed'({1'b0, item.col})) - SD_W'(signed'({1'b0, item.row}));
		load_diag    = load_d + SD_W'(MAX_LOWER);
		load_in_band = (load_d >= -SD_W'(signed'({1'b0, lw_eff})))
			&& (load_d <= SD_W'(signed'({1'b0, uw_eff})));
	end

	// Column range of the current row: from i - lower_width, clipped at
	// zero, up to i + upper_width, clipped at the last column. A row that
	// lies wholly right of the matrix gets an empty range.
	always_comb begin
		lo_skip = ({2'b00, lw_eff} < i_q) ? {2'b00, lw_eff} : i_q;
		row_lo  = i_q - lo_skip;
		hi_raw  = {1'b0, i_q} + DIM_W'(uw_eff);
		row_hi  = (hi_raw < cols_eff - DIM_W'(1)) ? hi_raw : cols_eff - DIM_W'(1);
		if (row_hi >= {1'b0, row_lo}) begin
			row_len = row_hi - {1'b0, row_lo} + DIM_W'(1);
		end else begin
			row_len = '0;
		end
		last_row = ({1'b0, i_q} == rows_eff - DIM_W'(1));
	end

	assign out_free = !out_valid_q || !result_stall;

	// Rounding to Q8.8 is a floor shift after adding half a step, then the
	// value saturates to the element range.
	always_comb begin
		scaled = sum_q >>> (2 * FRAC_W);
		if (scaled > SAT_HI) begin
			y_sat = SAT_HI[DATA_W-1:0];
		end else if (scaled < SAT_LO) begin
			y_sat = SAT_LO[DATA_W-1:0];
		end else begin
			y_sat = scaled[DATA_W-1:0];
		end
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == BAND_AW'(BAND_DEPTH - 1)) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept && item.op == OP_START) begin
					state_nxt = ST_ROW;
				end
			end
			ST_ROW: begin
				state_nxt = ST_MAC;
			end
			ST_MAC: begin
				if (cnt_q == '0 && !rd_vld_s1 && !prod_vld_s2) begin
					state_nxt = ST_ALPHA;
				end
			end
			ST_ALPHA: begin
				state_nxt = ST_BETA;
			end
			ST_BETA: begin
				state_nxt = ST_SUM;
			end
			ST_SUM: begin
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_nxt = last_row ? ST_IDLE : ST_ROW;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		item_stall   = 1'b1;
		issue        = 1'b0;
		out_load     = 1'b0;
		mul_ctrl.en  = 1'b0;
		mul_ctrl.sel = MUL_BAND;
		band_we      = 1'b0;
		band_wr_addr = clr_addr_q;
		band_wr_data = '0;
		x_we         = 1'b0;
		y_we         = 1'b0;
		y_wr_addr    = item.row;
		y_wr_data    = item.value;
		case (state_q)
			ST_CLEAR: begin
				band_we = 1'b1;
			end
			ST_IDLE: begin
				item_stall   = 1'b0;
				band_we      = accept && item.op == OP_LOAD_A && load_in_band;
				band_wr_addr = {item.row, load_diag[DIAG_W-1:0]};
				band_wr_data = item.value;
				x_we         = accept && item.op == OP_LOAD_X;
				y_we         = accept && item.op == OP_LOAD_Y;
			end
			ST_MAC: begin
				issue       = (cnt_q != '0);
				mul_ctrl.en = rd_vld_s1;
			end
			ST_ALPHA: begin
				mul_ctrl.en  = 1'b1;
				mul_ctrl.sel = MUL_ALPHA;
			end
			ST_BETA: begin
				mul_ctrl.en  = 1'b1;
				mul_ctrl.sel = MUL_BETA;
			end
			ST_OUT: begin
				out_load  = out_free;
				y_we      = out_free;
				y_wr_addr = i_q;
				y_wr_data = y_sat;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			i_q         <= '0;
			j_q         <= '0;
			diag_q      <= '0;
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			prod_vld_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rd_vld_s1   <= issue;
			prod_vld_s2 <= (state_q == ST_MAC) && rd_vld_s1;

			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + BAND_AW'(1);
			end

			if (state_q == ST_IDLE && accept && item.op == OP_START) begin
				i_q <= '0;
			end else if (out_load && !last_row) begin
				i_q <= i_q + IDX_W'(1);
			end

			if (state_q == ST_ROW) begin
				j_q    <= row_lo;
				diag_q <= DIAG_W'(MAX_LOWER) - DIAG_W'(lo_skip);
				cnt_q  <= CNT_W'(row_len);
			end else if (issue) begin
				j_q    <= j_q + IDX_W'(1);
				diag_q <= diag_q + DIAG_W'(1);
				cnt_q  <= cnt_q - CNT_W'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q   <= DIM_W'(MAX_DIM);
			col_count_q   <= DIM_W'(MAX_DIM);
			lower_width_q <= '0;
			upper_width_q <= '0;
			alpha_gain_q  <= DATA_W'(1 << FRAC_W);
			beta_gain_q   <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_ROW_COUNT:   row_count_q   <= cfg_data[DIM_W-1:0];
				REG_COL_COUNT:   col_count_q   <= cfg_data[DIM_W-1:0];
				REG_LOWER_WIDTH: lower_width_q <= cfg_data[BW_W-1:0];
				REG_UPPER_WIDTH: upper_width_q <= cfg_data[BW_W-1:0];
				REG_ALPHA_GAIN:  alpha_gain_q  <= cfg_data[DATA_W-1:0];
				REG_BETA_GAIN:   beta_gain_q   <= cfg_data[DATA_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Accumulation and final sum. The row sum is exact; the alpha product
	// is parked while the multiplier forms beta times the old y.
	always_ff @(posedge clk) begin
		if (state_q == ST_ROW) begin
			acc_q <= '0;
		end else if (prod_vld_s2) begin
			acc_q <= acc_q + prod_s2[ACC_W-1:0];
		end

		if (state_q == ST_BETA) begin
			tot_q <= prod_s2;
		end

		if (state_q == ST_SUM) begin
			sum_q <= SUM_W'(tot_q) + (SUM_W'(prod_s2) <<< FRAC_W) + ROUND_HALF;
		end

		if (out_load) begin
			out_q.y_value <= y_sat;
			out_q.y_index <= i_q;
			out_q.last    <= last_row;
		end
	end

	// Memories, each with one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (band_we) begin
			band_mem[band_wr_addr] <= band_wr_data;
		end
		band_rd_q <= band_mem[{i_q, diag_q}];
	end

	always_ff @(posedge clk) begin
		if (x_we) begin
			x_mem[item.col] <= item.value;
		end
		x_rd_q <= x_mem[j_q];
	end

	always_ff @(posedge clk) begin
		if (y_we) begin
			y_mem[y_wr_addr] <= y_wr_data;
		end
		y_rd_q <= y_mem[i_q];
	end

	bmv_mul_unit #(
		.ACC_W (ACC_W)
	) u_mul (
		.clk     (clk),
		.ctrl    (mul_ctrl),
		.band_rd (band_rd_q),
		.x_rd    (x_rd_q),
		.y_rd    (y_rd_q),
		.acc     (acc_q),
		.alpha   (alpha_gain_q),
		.beta    (beta_gain_q),
		.prod_s2 (prod_s2)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

>>> src/bmv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmv_checker: port-level checks of the band matrix-vector multiplier
// Watches the item and result channels and flags sequencing slips.
// ----------------------------------------------------------------------------
module bmv_checker import bmv_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    item_valid,
	input logic    item_stall,
	input item_t   item,
	input logic    result_valid,
	input logic    result_stall,
	input result_t result
);

	// A result that is not the last of a compute means rows remain, so the
	// block cannot be taking items.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> item_stall)
	else $error("item channel open while a compute is still running");

	// A load completes in its own cycle and leaves the block ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op != OP_START |=> !item_stall)
	else $error("block not ready after a load transfer");

	// A start transfer begins a compute that blocks further items.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.op == OP_START |=> item_stall)
	else $error("block ready right after a start transfer");

	// A stalled result holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
	else $error("stalled result changed or was dropped");

endmodule

bind band_matrix_vector_multiply bmv_checker u_bmv_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

>>> verif/band_matrix_vector_multiply_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// band_matrix_vector_multiply_test: self-checking bench for the band multiplier
// Drives load and start items with bursty timing against a stalling result
// sink and checks every y element against a behavioral model of y = aAx + by.
// ----------------------------------------------------------------------------
module band_matrix_vector_multiply_test;

	import bmv_pkg::*;

	// The band is held as 31 diagonals per row, the main diagonal at BW_MAX.
	localparam int BAND_SPAN      = 2 * BW_MAX + 1;
	// Cycles without any transfer before the run is declared hung. The sweep
	// that clears the band memory after reset is the longest quiet stretch.
	localparam int WATCHDOG_LIMIT = 20000;
	// Quiet cycles let pass after the last expected result, before a register
	// write or the end of the run.
	localparam int SETTLE_CYCLES  = 64;
	// Number of x elements loaded at the start; random sizes stay within it.
	localparam int X_LOADED       = 16;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic    clk;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ROW_COUNT;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Items waiting to be driven, and y elements the block still owes us.
	item_t   items_to_send [$];
	result_t expected_y    [$];
	int unsigned error_count  = 0;
	int unsigned quiet_cycles = 0;

	// Shadow copy of the block's registers and stores. The band store starts
	// at zero like the real one; x and y are loaded before any compute.
	logic [DIM_W-1:0]         row_count_q = 7'd64;
	logic [DIM_W-1:0]         col_count_q = 7'd64;
	logic [BW_W-1:0]          lower_q     = '0;
	logic [BW_W-1:0]          upper_q     = '0;
	logic signed [DATA_W-1:0] alpha_q     = 16'sd256;
	logic signed [DATA_W-1:0] beta_q      = '0;
	bit signed [DATA_W-1:0]   band_mem [MAX_DIM][BAND_SPAN];
	bit signed [DATA_W-1:0]   x_mem    [MAX_DIM];
	bit signed [DATA_W-1:0]   y_mem    [MAX_DIM];

	band_matrix_vector_multiply u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Size registers of 0 behave as 1 and anything past the store as its size.
	function automatic int effective_dim(input logic [DIM_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return int'(v);
	endfunction

	// Applies one accepted item to the shadow state. A start walks every row
	// over its band, sums the Q16.16 products exactly, scales by alpha, adds
	// beta * y moved up to Q24.24, rounds half up to Q8.8 and saturates. Each
	// result also replaces the old y element, as the block does.
	task automatic apply_band_item(input item_t it);
		int  d, rows, cols, lw, uw, lo, hi;
		longint acc, total;
		logic signed [DATA_W-1:0] y_new;
		result_t res;
		lw = int'(lower_q);
		uw = int'(upper_q);
		case (it.op)
			OP_LOAD_A: begin
				// Elements outside the current band are dropped.
				d = int'(it.col) - int'(it.row);
				if (d >= -lw && d <= uw)
					band_mem[it.row][d + BW_MAX] = it.value;
			end
			OP_LOAD_X: x_mem[it.col] = it.value;
			OP_LOAD_Y: y_mem[it.row] = it.value;
			OP_START: begin
				rows = effective_dim(row_count_q);
				cols = effective_dim(col_count_q);
				for (int i = 0; i < rows; i++) begin
					lo = (i - lw < 0) ? 0 : i - lw;
					hi = (i + uw > cols - 1) ? cols - 1 : i + uw;
					acc = 0;
					for (int j = lo; j <= hi; j++)
						acc += longint'(band_mem[i][j - i + BW_MAX]) * longint'(x_mem[j]);
					total = longint'(alpha_q) * acc
						+ ((longint'(beta_q) * longint'(y_mem[i])) <<< FRAC_W)
						+ (longint'(1) <<< (2 * FRAC_W - 1));
					total = total >>> (2 * FRAC_W);
					if (total > 32767)
						y_new = 16'sh7fff;
					else if (total < -32768)
						y_new = 16'sh8000;
					else
						y_new = total[DATA_W-1:0];
					y_mem[i] = y_new;
					res.y_value = y_new;
					res.y_index = i[IDX_W-1:0];
					res.last    = (i == rows - 1);
					expected_y.push_back(res);
				end
			end
			default: ;
		endcase
	endtask

	// Sender: bursts of random length separated by random gaps. A payload is
	// held while stalled; a new one is taken only once the current transfer
	// has happened, so each signal gets one assignment per edge.
	int burst_left;
	int gap_left;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
			burst_left <= 0;
			gap_left   <= 0;
		end else begin
			if (item_valid && !item_stall)
				apply_band_item(item);
			if (!item_valid || !item_stall) begin
				if (gap_left != 0) begin
					item_valid <= 1'b0;
					gap_left   <= gap_left - 1;
				end else if (items_to_send.size() != 0) begin
					item       <= items_to_send.pop_front();
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 16);
						// A quarter of the bursts run straight into the next.
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: the stall behavior switches among four modes at random
	// intervals, including stretches with no stall at all.
	stall_mode_t stall_mode;
	int          mode_left;
	int unsigned stall_phase;
	result_t     want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_mode   <= STALL_NONE;
			mode_left    <= 0;
			stall_phase  <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_y.size() == 0) begin
					$error("result with nothing expected: y_index %0d y_value %0d",
						result.y_index, $signed(result.y_value));
					error_count++;
				end else begin
					want = expected_y.pop_front();
					if (result.y_value !== want.y_value) begin
						$error("y_value: expected %0d, actual %0d",
							$signed(want.y_value), $signed(result.y_value));
						error_count++;
					end
					if (result.y_index !== want.y_index) begin
						$error("y_index: expected %0d, actual %0d", want.y_index, result.y_index);
						error_count++;
					end
					if (result.last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, result.last);
						error_count++;
					end
				end
			end
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
				mode_left  <= $urandom_range(20, 200);
			end else begin
				mode_left <= mode_left - 1;
			end
			stall_phase <= stall_phase + 1;
			case (stall_mode)
				STALL_NONE:     result_stall <= 1'b0;
				STALL_LIGHT:    result_stall <= ($urandom_range(0, 3) == 0);
				STALL_HEAVY:    result_stall <= ($urandom_range(0, 3) != 0);
				STALL_PERIODIC: result_stall <= ((stall_phase % 5) < 2);
				default:        result_stall <= 1'b0;
			endcase
		end
	end

	// Hang detection: any transfer on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles == WATCHDOG_LIMIT) begin
				$display("** band_matrix_vector_multiply: FAILED **");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// The callers make register writes only while the block is idle or in its
	// reset sweep; this task does not enforce it. The shadow copy is updated at once.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_ROW_COUNT:   row_count_q = data[DIM_W-1:0];
			REG_COL_COUNT:   col_count_q = data[DIM_W-1:0];
			REG_LOWER_WIDTH: lower_q     = data[BW_W-1:0];
			REG_UPPER_WIDTH: upper_q     = data[BW_W-1:0];
			REG_ALPHA_GAIN:  alpha_q     = data;
			REG_BETA_GAIN:   beta_q      = data;
			default: ;
		endcase
	endtask

	task automatic set_config(input int rows, input int cols, input int lower,
		input int upper, input logic [CFG_W-1:0] alpha, input logic [CFG_W-1:0] beta);
		write_reg(REG_ROW_COUNT, rows[CFG_W-1:0]);
		write_reg(REG_COL_COUNT, cols[CFG_W-1:0]);
		write_reg(REG_LOWER_WIDTH, lower[CFG_W-1:0]);
		write_reg(REG_UPPER_WIDTH, upper[CFG_W-1:0]);
		write_reg(REG_ALPHA_GAIN, alpha);
		write_reg(REG_BETA_GAIN, beta);
	endtask

	task automatic queue_item(input op_t op, input int row, input int col,
		input logic [DATA_W-1:0] value);
		item_t it;
		it.op    = op;
		it.row   = row[IDX_W-1:0];
		it.col   = col[IDX_W-1:0];
		it.value = value;
		items_to_send.push_back(it);
	endtask

	// Waits until the sender is empty and every y element has come back,
	// then lets the block settle. This is also where the sender pauses.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (items_to_send.size() != 0 || item_valid || expected_y.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [DATA_W-1:0] random_value();
		case ($urandom_range(0, 5))
			0: begin
				case ($urandom_range(0, 5))
					0: return 16'h7fff;
					1: return 16'h8000;
					2: return 16'h0000;
					3: return 16'hffff;
					4: return 16'h0001;
					default: return 16'h0100;
				endcase
			end
			1, 2: return DATA_W'($urandom_range(0, 1023) - 512);
			3: return DATA_W'($urandom_range(0, 255) - 128);
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Sizes favor small matrices so computes stay short and stay within the
	// loaded x elements; a size of zero shows up now and then.
	function automatic int random_dim();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick < 13)
			return $urandom_range(1, 12);
		if (pick < 19)
			return $urandom_range(13, X_LOADED);
		return 0;
	endfunction

	// Most loads land inside the current band and inside the active rows and
	// columns, so they feed the next compute; the rest are random noise.
	function automatic item_t random_item();
		item_t it;
		int    pick, rows, cols, lw, uw, d, c;
		rows     = effective_dim(row_count_q);
		cols     = effective_dim(col_count_q);
		lw       = int'(lower_q);
		uw       = int'(upper_q);
		pick     = $urandom_range(0, 99);
		it.value = random_value();
		it.row   = IDX_W'($urandom);
		it.col   = IDX_W'($urandom);
		if (pick < 8) begin
			it.op = OP_START;
		end else if (pick < 48) begin
			it.op  = OP_LOAD_A;
			it.row = IDX_W'($urandom_range(0, rows - 1));
			d      = int'($urandom_range(0, lw + uw)) - lw;
			c      = int'(it.row) + d;
			it.col = (c >= 0 && c < MAX_DIM) ? c[IDX_W-1:0] : it.row;
		end else if (pick < 58) begin
			it.op = OP_LOAD_A;
		end else if (pick < 79) begin
			it.op = OP_LOAD_X;
			if ($urandom_range(0, 3) != 0)
				it.col = IDX_W'($urandom_range(0, cols - 1));
		end else begin
			it.op = OP_LOAD_Y;
			if ($urandom_range(0, 3) != 0)
				it.row = IDX_W'($urandom_range(0, rows - 1));
		end
		return it;
	endfunction

	// Stimulus. Reset is applied once; the first compute runs on a 16 by 16
	// matrix with every other register at its reset value and a band store
	// cleared by the sweep apart from the diagonal loads below.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_reg(REG_ROW_COUNT, CFG_W'(X_LOADED));
		write_reg(REG_COL_COUNT, CFG_W'(X_LOADED));

		// Every y element and the first x elements get a value first, so no
		// compute ever reads an entry that was never written.
		for (int k = 0; k < MAX_DIM; k++)
			queue_item(OP_LOAD_Y, k, 0, random_value());
		for (int k = 0; k < X_LOADED; k++)
			queue_item(OP_LOAD_X, 0, k, random_value());

		// Diagonal band only: the extremes of the value range, a product that
		// saturates, an exact half that must round up, and two loads that fall
		// outside the band and must be ignored.
		queue_item(OP_LOAD_A, 0, 0, 16'h7fff);
		queue_item(OP_LOAD_A, 1, 1, 16'h8000);
		queue_item(OP_LOAD_A, 2, 2, 16'h0001);
		queue_item(OP_LOAD_A, 15, 15, 16'hffff);
		queue_item(OP_LOAD_A, 0, 1, 16'h04d2);
		queue_item(OP_LOAD_A, 5, 3, 16'hfff9);
		queue_item(OP_LOAD_X, 0, 0, 16'h7fff);
		queue_item(OP_LOAD_X, 0, 1, 16'h8000);
		queue_item(OP_LOAD_X, 0, 2, 16'h0080);
		queue_item(OP_LOAD_X, 0, 15, 16'h8000);
		queue_item(OP_LOAD_Y, 0, 0, 16'h8000);
		queue_item(OP_START, 0, 0, 16'h0000);
		wait_drained();

		// A row count of 0 acts as one row and a column count past the store
		// as the full width; the widest band, gains at their extremes.
		set_config(0, 127, 15, 15, 16'h8000, 16'h7fff);
		queue_item(OP_LOAD_A, 0, 15, 16'h8000);
		queue_item(OP_LOAD_A, 0, 0, 16'h7fff);
		queue_item(OP_LOAD_X, 0, 15, 16'h8000);
		queue_item(OP_LOAD_Y, 0, 0, 16'h7fff);
		queue_item(OP_START, 63, 63, 16'hffff);
		wait_drained();

		// A single column against the full height of the matrix.
		set_config(127, 0, 15, 15, 16'h7fff, 16'h8000);
		queue_item(OP_LOAD_A, 15, 0, 16'h7fff);
		queue_item(OP_LOAD_A, 1, 0, 16'hffff);
		queue_item(OP_LOAD_X, 0, 0, 16'hffff);
		queue_item(OP_START, 0, 0, 16'h0000);
		wait_drained();

		// Narrowing the band hides the diagonals loaded above; the random
		// phases that follow may widen it again and bring them back.
		set_config(16, 16, 1, 1, 16'h0100, 16'h0000);
		for (int k = 0; k < 12; k++)
			items_to_send.push_back(random_item());
		queue_item(OP_START, 0, 0, 16'h0000);
		wait_drained();

		// Random phases, each with fresh register values and ending in a start.
		for (int p = 0; p < 2; p++) begin
			set_config(random_dim(), random_dim(), $urandom_range(0, BW_MAX),
				$urandom_range(0, BW_MAX), random_value(), random_value());
			for (int k = 0; k < 8; k++)
				items_to_send.push_back(random_item());
			queue_item(OP_START, 0, 0, 16'h0000);
			wait_drained();
		end

		if (error_count == 0)
			$display("** band_matrix_vector_multiply: PASSED **");
		else
			$display("** band_matrix_vector_multiply: FAILED **");
		$finish;
	end

endmodule
